// ===== rtl/gpp_pkg.sv =====
// Shared constants, opcodes and controller/datapath handshake types of the principal pool.
package gpp_pkg;

  // Default pool size and capability mask width.
  localparam int SLOTS_DEF    = 64;
  localparam int CAP_BITS_DEF = 64;

  // Field widths of one slot entry and of a handle.
  localparam int GEN_W = 32;
  localparam int RC_W  = 32;
  localparam int HND_W = 64;

  // Request opcodes.
  localparam logic [2:0] OP_CREATE     = 3'd0;
  localparam logic [2:0] OP_ADDREF     = 3'd1;
  localparam logic [2:0] OP_RELEASE    = 3'd2;
  localparam logic [2:0] OP_BUMP       = 3'd3;
  localparam logic [2:0] OP_ALLOWS     = 3'd4;
  localparam logic [2:0] OP_HANDLEOF   = 3'd5;
  localparam logic [2:0] OP_FROMHANDLE = 3'd6;
  localparam logic [2:0] OP_ACQUIRE    = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one zero entry of the clearing pass
    logic accept;  // latch the incoming request and start the slot read
    logic exec;    // update the slot and load the result register
  } gpp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is at its last entry
    logic out_busy;    // the result register holds a result not yet taken
  } gpp_stat_t;

endpackage

// ===== rtl/gpp_in_if.sv =====
// Request channel of the principal pool.
interface gpp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [5:0]  slot_index;
  logic [63:0] handle_in;
  logic [63:0] caps_in;
  logic [5:0]  cap_kind;

  modport source (output valid, opcode, slot_index, handle_in, caps_in, cap_kind,
                  input ready);
  modport sink   (input valid, opcode, slot_index, handle_in, caps_in, cap_kind,
                  output ready);
endinterface

// ===== rtl/gpp_out_if.sv =====
// Result channel of the principal pool.
interface gpp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [5:0]  slot_out;
  logic [63:0] handle_out;

  modport source (output valid, ok, slot_out, handle_out, input ready);
  modport sink   (input valid, ok, slot_out, handle_out, output ready);
endinterface

// ===== rtl/gpp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gpp_ctrl.sv =====
// Controller of the principal pool: clearing pass, request intake and slot update sequencing.
module gpp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpp_pkg::gpp_stat_t stat,
  output gpp_pkg::gpp_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The update waits until the result register can take the answer.
        if (!stat.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/gpp_dp.sv =====
// Datapath of the principal pool: slot store, active flags, target decode and result register.
module gpp_dp #(
  parameter int SLOTS    = gpp_pkg::SLOTS_DEF,
  parameter int CAP_BITS = gpp_pkg::CAP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gpp_pkg::gpp_cmd_t  cmd,
  output gpp_pkg::gpp_stat_t stat,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_slot_index,
  input  logic [63:0]        in_handle_in,
  input  logic [63:0]        in_caps_in,
  input  logic [5:0]         in_cap_kind,
  gpp_out_if.source          out_ch
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int GEN_W = gpp_pkg::GEN_W;
  localparam int RC_W  = gpp_pkg::RC_W;
  localparam int EW    = GEN_W + RC_W + CAP_BITS;

  // Control state.
  logic [SLOTS-1:0] act_r;
  logic [IDX_W-1:0] cnt_r;
  logic             out_valid_r;

  // Latched request.
  logic [2:0]          op_r;
  logic [5:0]          sidx_r;
  logic [63:0]         hnd_r;
  logic [CAP_BITS-1:0] caps_r;
  logic [5:0]          kind_r;
  logic [IDX_W-1:0]    tgt_r;
  logic                tgt_ok_r;

  // Result register.
  logic        ok_r;
  logic [5:0]  so_r;
  logic [63:0] ho_r;

  // Target decode.
  logic [SLOTS-1:0] free_v;
  logic [SLOTS-1:0] ff_oh;
  logic [IDX_W-1:0] ff_idx;
  logic             any_free;
  logic [31:0]      hlo;
  logic [31:0]      hhi;
  logic [31:0]      hslot;
  logic [IDX_W-1:0] tgt;
  logic             tgt_ok;

  // Slot store access.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [EW-1:0]    ram_rdata;

  // Update logic.
  logic [GEN_W-1:0]    gen;
  logic [RC_W-1:0]     rc;
  logic [CAP_BITS-1:0] cap;
  logic [63:0]         cap64;
  logic                live;
  logic [GEN_W-1:0]    gen_inc;
  logic [GEN_W-1:0]    gen_nx;
  logic [GEN_W-1:0]    gen_cr;
  logic                rc_max;
  logic [RC_W-1:0]     rc_dec;
  logic [31:0]         enc;
  logic                hmatch;
  logic [GEN_W-1:0]    n_gen;
  logic [RC_W-1:0]     n_rc;
  logic [CAP_BITS-1:0] n_cap;
  logic                wr;
  logic                act_set;
  logic                act_clr;
  logic                r_ok;
  logic [5:0]          r_so;
  logic [63:0]         r_ho;

  // First free slot: isolate the lowest clear active flag, then encode it.
  always_comb begin
    free_v   = ~act_r;
    ff_oh    = free_v & (~free_v + SLOTS'(1));
    any_free = |free_v;
    ff_idx   = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (ff_oh[j]) begin
        ff_idx = ff_idx | IDX_W'(j);
      end
    end
  end

  // Slot addressed by the incoming request and whether it lies in the pool.
  assign hlo   = in_handle_in[31:0];
  assign hhi   = in_handle_in[63:32];
  assign hslot = hlo - 32'd1;

  always_comb begin
    unique case (in_opcode)
      gpp_pkg::OP_CREATE: begin
        tgt    = ff_idx;
        tgt_ok = any_free;
      end
      gpp_pkg::OP_FROMHANDLE, gpp_pkg::OP_ACQUIRE: begin
        tgt    = IDX_W'(hslot);
        tgt_ok = (hlo != 32'd0) && (hhi != 32'd0) && (hslot < 32'(SLOTS));
      end
      default: begin
        tgt    = IDX_W'(in_slot_index);
        tgt_ok = 32'(in_slot_index) < 32'(SLOTS);
      end
    endcase
  end

  // Request latch; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_opcode;
      sidx_r   <= in_slot_index;
      hnd_r    <= in_handle_in;
      caps_r   <= CAP_BITS'(in_caps_in);
      kind_r   <= in_cap_kind;
      tgt_r    <= tgt;
      tgt_ok_r <= tgt_ok;
    end
  end

  // Slot entry fields as read back from the store.
  assign gen     = ram_rdata[EW-1 -: GEN_W];
  assign rc      = ram_rdata[CAP_BITS +: RC_W];
  assign cap     = ram_rdata[CAP_BITS-1:0];
  assign cap64   = 64'(cap);
  assign live    = tgt_ok_r && act_r[tgt_r];
  assign gen_inc = gen + GEN_W'(1);
  assign gen_nx  = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign gen_cr  = (gen == '0) ? GEN_W'(1) : gen;
  assign rc_max  = &rc;
  assign rc_dec  = (rc == '0) ? '0 : rc - RC_W'(1);
  assign enc     = 32'(tgt_r) + 32'd1;
  assign hmatch  = live && (gen == hnd_r[63:32]);

  // Slot update and answer for the latched request.
  always_comb begin
    n_gen   = gen;
    n_rc    = rc;
    n_cap   = cap;
    wr      = 1'b0;
    act_set = 1'b0;
    act_clr = 1'b0;
    r_ok    = 1'b0;
    r_so    = sidx_r;
    r_ho    = (live && (gen != '0)) ? {gen, enc} : 64'd0;
    unique case (op_r)
      gpp_pkg::OP_CREATE: begin
        r_so = '0;
        r_ho = '0;
        if (tgt_ok_r) begin
          n_cap   = caps_r;
          n_gen   = gen_cr;
          n_rc    = RC_W'(1);
          wr      = 1'b1;
          act_set = 1'b1;
          r_ok    = 1'b1;
          r_so    = 6'(tgt_r);
          r_ho    = {gen_cr, enc};
        end
      end
      gpp_pkg::OP_ADDREF: begin
        if (live && !rc_max) begin
          n_rc = rc + RC_W'(1);
          wr   = 1'b1;
          r_ok = 1'b1;
        end
      end
      gpp_pkg::OP_RELEASE: begin
        if (live) begin
          n_rc = rc_dec;
          wr   = 1'b1;
          r_ok = 1'b1;
          // The last reference frees the slot and retires its handles.
          if (rc_dec == '0) begin
            act_clr = 1'b1;
            n_cap   = '0;
            n_gen   = gen_nx;
            r_ho    = '0;
          end
        end
      end
      gpp_pkg::OP_BUMP: begin
        if (live) begin
          n_gen = gen_nx;
          wr    = 1'b1;
          r_ok  = 1'b1;
          r_ho  = {gen_nx, enc};
        end
      end
      gpp_pkg::OP_ALLOWS: begin
        // Bits beyond the stored mask read as zero after extension.
        r_ok = live && cap64[kind_r];
      end
      gpp_pkg::OP_HANDLEOF: begin
        r_ok = live && (gen != '0);
      end
      default: begin
        r_so = '0;
        r_ho = '0;
        if (hmatch) begin
          if (op_r == gpp_pkg::OP_FROMHANDLE) begin
            r_ok = 1'b1;
          end else if (!rc_max) begin
            n_rc = rc + RC_W'(1);
            wr   = 1'b1;
            r_ok = 1'b1;
          end
          if (r_ok) begin
            r_so = 6'(tgt_r);
            r_ho = hnd_r;
          end
        end
      end
    endcase
  end

  // Store port selection: the clearing pass writes zeros, otherwise the update writes back.
  assign ram_we    = cmd.clear || (cmd.exec && wr);
  assign ram_waddr = cmd.clear ? cnt_r : tgt_r;
  assign ram_wdata = cmd.clear ? '0 : {n_gen, n_rc, n_cap};
  assign ram_raddr = cmd.accept ? tgt : tgt_r;

  gpp_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Active flags, clearing counter and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.exec && act_set) begin
        act_r[tgt_r] <= 1'b1;
      end else if (cmd.exec && act_clr) begin
        act_r[tgt_r] <= 1'b0;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r <= r_ok;
      so_r <= r_so;
      ho_r <= r_ho;
    end
  end

  assign stat.clear_last = (cnt_r == IDX_W'(SLOTS - 1));
  assign stat.out_busy   = out_valid_r && !out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = ok_r;
  assign out_ch.slot_out   = so_r;
  assign out_ch.handle_out = ho_r;

endmodule

// ===== rtl/generational_principal_pool_unit.sv =====
// Top level of the generational principal pool: controller, datapath and channel wiring.
//
// Requests arrive on in_ch (valid/ready); each one names an opcode, a slot, a handle,
// a capability mask and a capability bit. Every request yields exactly one result on
// out_ch: ok, the slot taken or found, and the slot's handle after the operation.
// A request is taken while its slot entry is read from the slot store; in the update
// step that follows, the entry is written back and the result register is loaded once
// that register is free, and the result is then valid on out_ch. The block takes no new
// request until the previous one has passed the update step, set by the single
// read-then-write access to the slot store per request.
// in_ready is high again right after the update, even while the previous result still
// waits on out_ch; if the receiver stalls, the next request holds in the update step
// until the result register is free, and nothing is lost or repeated.
// After rst_n the slot store is cleared one entry per cycle, all SLOTS entries in turn,
// during which in_ready stays low; active flags clear at once. Free slots are found
// by a priority encode of the active flags, lowest index first.
module generational_principal_pool_unit #(
  parameter int SLOTS    = gpp_pkg::SLOTS_DEF,
  parameter int CAP_BITS = gpp_pkg::CAP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gpp_in_if.sink    in_ch,
  gpp_out_if.source out_ch
);

  gpp_pkg::gpp_cmd_t  cmd;
  gpp_pkg::gpp_stat_t stat;
  logic               in_rdy;

  // Sequencing of clear, intake and update.
  gpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_rdy;

  // Slot store and request processing.
  gpp_dp #(
    .SLOTS    (SLOTS),
    .CAP_BITS (CAP_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_opcode     (in_ch.opcode),
    .in_slot_index (in_ch.slot_index),
    .in_handle_in  (in_ch.handle_in),
    .in_caps_in    (in_ch.caps_in),
    .in_cap_kind   (in_ch.cap_kind),
    .out_ch        (out_ch)
  );

endmodule
